FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/vara_pkg.sv
// ---------------------------------------------------------------------------
// Vector alignment rotation package
// Types, constants and lane tables shared by the rotation matrix pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package vara_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int NUM_LANES     = 6;
    localparam int QBITS         = 63;

    localparam logic [QBITS-1:0] Q_LIMIT = QBITS'(1) << 62;

    typedef struct packed {
        logic signed [15:0] from_x;
        logic signed [15:0] from_y;
        logic signed [15:0] from_z;
        logic signed [15:0] to_x;
        logic signed [15:0] to_y;
        logic signed [15:0] to_z;
    } vec_pair_t;

    typedef struct packed {
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m13;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [15:0] m23;
        logic signed [15:0] m31;
        logic signed [15:0] m32;
        logic signed [15:0] m33;
        logic               degenerate;
    } mat_t;

    typedef struct packed {
        logic [63:0]       rem;
        logic [QBITS-1:0]  lo;
        logic [QBITS-1:0]  q;
        logic              sat;
        logic              neg;
    } lane_t;

    typedef lane_t [NUM_LANES-1:0] lane_vec_t;

    typedef struct packed {
        logic [63:0]        n;
        logic signed [32:0] v0;
        logic signed [32:0] v1;
        logic signed [32:0] v2;
        logic               deg;
    } side_t;

    // Lanes 0 to 2 hold the diagonal, lanes 3 to 5 the symmetric off-diagonal pairs.
    function automatic int lane_i(input int l);
        case (l)
            0, 3, 4: return 0;
            1, 5:    return 1;
            default: return 2;
        endcase
    endfunction

    function automatic int lane_j(input int l);
        case (l)
            0:       return 0;
            1, 3:    return 1;
            default: return 2;
        endcase
    endfunction

    function automatic int lane_of(input int i, input int j);
        if (i == j)
            return i;
        else if (i + j == 1)
            return 3;
        else if (i + j == 2)
            return 4;
        else
            return 5;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/vara_stream_if.sv
// ---------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface vara_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/vector_align_rotation_matrix.sv
// ---------------------------------------------------------------------------
// Vector alignment rotation matrix
// Rodrigues rotation that carries one fixed-point unit vector onto another.
// ---------------------------------------------------------------------------
// The block takes a pair of 3-D vectors on in_vec and returns the 3x3
// rotation matrix, in the same fixed-point format, on out_mat. Both channels
// move one item per valid/ready transfer.
// A new pair may be transferred in every cycle while in_vec.ready is high.
// The result of a pair reaches out_mat through six stages of products and
// sums, then the six-lane divider, which resolves one quotient bit per
// pipeline stage over 63 stages, then two stages that form and round the
// entries.
// When the receiver holds ready low, the waiting result stays in the output
// register and one more result is caught in a skid register; only then does
// the whole pipeline hold and in_vec.ready fall, losing nothing.
// Parallel or opposite vectors, or a zero vector, give the identity matrix with degenerate set.
// Reset clears every valid bit; no result is presented until a new transfer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vector_align_rotation_matrix
    import vara_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    vara_stream_if.sink   in_vec,
    vara_stream_if.source out_mat
);

    localparam int FMAG_W = ((2 * FRAC_BITS > 32) ? 2 * FRAC_BITS : 32) + 1;
    localparam int FW     = FMAG_W + 1;
    localparam int FHI_W  = FMAG_W - 32;
    localparam int PW     = 64 + FMAG_W;
    localparam int HI_W   = PW - QBITS;
    localparam int CMP_W  = (HI_W > 64) ? HI_W : 64;

    localparam logic signed [FW-1:0] F_ONE2  = FW'(1) << (2 * FRAC_BITS);
    localparam logic signed [64:0]   T_ONE2  = 65'(1) << (2 * FRAC_BITS);
    localparam logic [64:0]          HALF    = 65'(1) << (FRAC_BITS - 1);
    localparam logic signed [15:0]   ONE_OUT =
        (FRAC_BITS >= 15) ? 16'sd32767 : 16'(1 << FRAC_BITS);

    logic en;
    logic skid_vld_reg;
    logic out_vld_reg;
    mat_t out_reg;
    mat_t skid_reg;

    assign en           = !skid_vld_reg;
    assign in_vec.ready = en;

    // Stage 1: all cross products of the components.
    logic signed [15:0] a [3];
    logic signed [15:0] b [3];
    logic               s1_vld_reg;
    logic signed [31:0] s1_p_reg [3][3];

    always_comb
    begin
        a[0] = in_vec.data.from_x;
        a[1] = in_vec.data.from_y;
        a[2] = in_vec.data.from_z;
        b[0] = in_vec.data.to_x;
        b[1] = in_vec.data.to_y;
        b[2] = in_vec.data.to_z;
    end

    // Stage 2: cross product v and dot product c.
    logic               s2_vld_reg;
    logic signed [32:0] s2_v_reg [3];
    logic signed [32:0] s2_c_reg;

    // Stage 3: magnitude products of v and the factor f = 1 - c.
    logic               s3_vld_reg;
    logic [31:0]        vmag [3];
    logic [63:0]        s3_pp_reg [NUM_LANES];
    logic signed [32:0] s3_v_reg [3];
    logic signed [FW-1:0] f_val;
    logic [FMAG_W-1:0]  s3_fmag_reg;
    logic               s3_fneg_reg;

    // Stage 4: |v|^2 and the magnitudes and signs of K*K.
    logic               s4_vld_reg;
    logic [63:0]        s4_kk_reg [NUM_LANES];
    logic               s4_kkneg_reg [NUM_LANES];
    logic [63:0]        s4_n_reg;
    logic signed [32:0] s4_v_reg [3];
    logic [FMAG_W-1:0]  s4_fmag_reg;
    logic               s4_fneg_reg;

    // Stage 5: partial products of |K*K| times |f|.
    logic                  s5_vld_reg;
    logic [63:0]           s5_ll_reg [NUM_LANES];
    logic [63:0]           s5_hl_reg [NUM_LANES];
    logic [32+FHI_W-1:0]   s5_lh_reg [NUM_LANES];
    logic [32+FHI_W-1:0]   s5_hh_reg [NUM_LANES];
    logic                  s5_neg_reg [NUM_LANES];
    logic [63:0]           s5_n_reg;
    logic signed [32:0]    s5_v_reg [3];

    // Stage 6: full product and divider set-up.
    logic      s6_vld_reg;
    lane_vec_t s6_lane_reg;
    side_t     s6_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vec.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            vmag[i] = s2_v_reg[i][32] ? 32'(-s2_v_reg[i]) : 32'(s2_v_reg[i]);
        f_val = F_ONE2 - FW'(s2_c_reg);
    end

    always_ff @(posedge clk)
    begin
        logic [63:0]         n_sum;
        logic [PW-1:0]       prod;
        logic [HI_W-1:0]     prod_hi;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    s1_p_reg[i][j] <= 32'(a[i]) * 32'(b[j]);

            s2_v_reg[0] <= 33'(s1_p_reg[1][2]) - 33'(s1_p_reg[2][1]);
            s2_v_reg[1] <= 33'(s1_p_reg[2][0]) - 33'(s1_p_reg[0][2]);
            s2_v_reg[2] <= 33'(s1_p_reg[0][1]) - 33'(s1_p_reg[1][0]);
            s2_c_reg    <= 33'(s1_p_reg[0][0]) + 33'(s1_p_reg[1][1])
                         + 33'(s1_p_reg[2][2]);

            for (int l = 0; l < NUM_LANES; l++)
                s3_pp_reg[l] <= 64'(vmag[lane_i(l)]) * 64'(vmag[lane_j(l)]);
            s3_v_reg    <= s2_v_reg;
            s3_fmag_reg <= f_val[FW-1] ? FMAG_W'(-f_val) : FMAG_W'(f_val);
            s3_fneg_reg <= f_val[FW-1];

            n_sum = s3_pp_reg[0] + s3_pp_reg[1] + s3_pp_reg[2];
            s4_kk_reg[0]    <= s3_pp_reg[1] + s3_pp_reg[2];
            s4_kk_reg[1]    <= s3_pp_reg[0] + s3_pp_reg[2];
            s4_kk_reg[2]    <= s3_pp_reg[0] + s3_pp_reg[1];
            s4_kkneg_reg[0] <= 1'b1;
            s4_kkneg_reg[1] <= 1'b1;
            s4_kkneg_reg[2] <= 1'b1;
            for (int l = 3; l < NUM_LANES; l++)
            begin
                s4_kk_reg[l]    <= s3_pp_reg[l];
                s4_kkneg_reg[l] <= s3_v_reg[lane_i(l)][32] ^ s3_v_reg[lane_j(l)][32];
            end
            s4_n_reg    <= n_sum;
            s4_v_reg    <= s3_v_reg;
            s4_fmag_reg <= s3_fmag_reg;
            s4_fneg_reg <= s3_fneg_reg;

            for (int l = 0; l < NUM_LANES; l++)
            begin
                s5_ll_reg[l]  <= 64'(s4_kk_reg[l][31:0]) * 64'(s4_fmag_reg[31:0]);
                s5_hl_reg[l]  <= 64'(s4_kk_reg[l][63:32]) * 64'(s4_fmag_reg[31:0]);
                s5_lh_reg[l]  <= (32+FHI_W)'(s4_kk_reg[l][31:0])
                               * (32+FHI_W)'(s4_fmag_reg[FMAG_W-1:32]);
                s5_hh_reg[l]  <= (32+FHI_W)'(s4_kk_reg[l][63:32])
                               * (32+FHI_W)'(s4_fmag_reg[FMAG_W-1:32]);
                s5_neg_reg[l] <= s4_kkneg_reg[l] ^ s4_fneg_reg;
            end
            s5_n_reg <= s4_n_reg;
            s5_v_reg <= s4_v_reg;

            for (int l = 0; l < NUM_LANES; l++)
            begin
                prod = PW'(s5_ll_reg[l])
                     + (PW'(s5_hl_reg[l]) << 32)
                     + (PW'(s5_lh_reg[l]) << 32)
                     + (PW'(s5_hh_reg[l]) << 64);
                prod_hi = prod[PW-1:QBITS];
                s6_lane_reg[l].sat <= (CMP_W'(prod_hi) >= CMP_W'(s5_n_reg));
                s6_lane_reg[l].rem <= 64'(prod_hi);
                s6_lane_reg[l].lo  <= prod[QBITS-1:0];
                s6_lane_reg[l].q   <= '0;
                s6_lane_reg[l].neg <= s5_neg_reg[l];
            end
            s6_side_reg.n   <= s5_n_reg;
            s6_side_reg.v0  <= s5_v_reg[0];
            s6_side_reg.v1  <= s5_v_reg[1];
            s6_side_reg.v2  <= s5_v_reg[2];
            s6_side_reg.deg <= (s5_n_reg == 64'd0);
        end
    end

    // Divider: one quotient bit per stage.
    logic      div_vld  [QBITS+1];
    lane_vec_t div_lane [QBITS+1];
    side_t     div_side [QBITS+1];

    assign div_vld[0]  = s6_vld_reg;
    assign div_lane[0] = s6_lane_reg;
    assign div_side[0] = s6_side_reg;

    for (genvar g = 0; g < QBITS; g++)
    begin : g_div
        vara_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (div_vld[g]),
            .lane_in  (div_lane[g]),
            .side_in  (div_side[g]),
            .vld_out  (div_vld[g+1]),
            .lane_out (div_lane[g+1]),
            .side_out (div_side[g+1])
        );
    end

    // Stage 7: unrounded entries t = I + K + q.
    logic               s7_vld_reg;
    logic signed [64:0] s7_t_reg [3][3];
    logic               s7_deg_reg;

    function automatic logic signed [32:0] k_entry(
        input side_t s,
        input int    i,
        input int    j
    );
        logic signed [32:0] r;
        r = '0;
        if (i == 0 && j == 1) r = -s.v2;
        if (i == 0 && j == 2) r = s.v1;
        if (i == 1 && j == 0) r = s.v2;
        if (i == 1 && j == 2) r = -s.v0;
        if (i == 2 && j == 0) r = -s.v1;
        if (i == 2 && j == 1) r = s.v0;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_vld_reg <= 1'b0;
        else if (en)
            s7_vld_reg <= div_vld[QBITS];
    end

    always_ff @(posedge clk)
    begin
        lane_t              ln;
        logic [QBITS-1:0]   qs;
        logic signed [64:0] base;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    ln   = div_lane[QBITS][lane_of(i, j)];
                    qs   = (ln.sat || ln.q > Q_LIMIT) ? Q_LIMIT : ln.q;
                    base = ((i == j) ? T_ONE2 : 65'sd0)
                         + 65'(k_entry(div_side[QBITS], i, j));
                    s7_t_reg[i][j] <= ln.neg ? base - $signed(65'(qs))
                                             : base + $signed(65'(qs));
                end
            s7_deg_reg <= div_side[QBITS].deg;
        end
    end

    // Output stage: round half away from zero and saturate.
    function automatic logic signed [15:0] finish_entry(input logic signed [64:0] t);
        logic [64:0] mag;
        logic [64:0] m;
        mag = t[64] ? 65'(-t) : 65'(t);
        m   = (mag + HALF) >> FRAC_BITS;
        if (!t[64])
            return (m > 65'd32767) ? 16'sd32767 : 16'(m);
        else
            return (m > 65'd32768) ? -16'sd32768 : 16'(~m + 65'd1);
    endfunction

    mat_t res;

    always_comb
    begin
        if (s7_deg_reg)
        begin
            res = '0;
            res.m11 = ONE_OUT;
            res.m22 = ONE_OUT;
            res.m33 = ONE_OUT;
            res.degenerate = 1'b1;
        end
        else
        begin
            res.m11 = finish_entry(s7_t_reg[0][0]);
            res.m12 = finish_entry(s7_t_reg[0][1]);
            res.m13 = finish_entry(s7_t_reg[0][2]);
            res.m21 = finish_entry(s7_t_reg[1][0]);
            res.m22 = finish_entry(s7_t_reg[1][1]);
            res.m23 = finish_entry(s7_t_reg[1][2]);
            res.m31 = finish_entry(s7_t_reg[2][0]);
            res.m32 = finish_entry(s7_t_reg[2][1]);
            res.m33 = finish_entry(s7_t_reg[2][2]);
            res.degenerate = 1'b0;
        end
    end

    logic take;
    logic produce;

    assign take    = out_vld_reg && out_mat.ready;
    assign produce = en && s7_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (produce)
            begin
                if (!out_vld_reg || take)
                    out_vld_reg <= 1'b1;
                else
                    skid_vld_reg <= 1'b1;
            end
            else if (skid_vld_reg && take)
                skid_vld_reg <= 1'b0;
            else if (take)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            if (!out_vld_reg || take)
                out_reg <= res;
            else
                skid_reg <= res;
        end
        else if (skid_vld_reg && take)
            out_reg <= skid_reg;
    end

    assign out_mat.valid = out_vld_reg;
    assign out_mat.data  = out_reg;

    `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_vld_reg, out_vld_reg)
    `ASSERT_IMPLIES(a_skid_blocks_in, clk, rst_n, skid_vld_reg, !in_vec.ready)
    `ASSERT_NEXT(a_in_enters_s1, clk, rst_n, in_vec.valid && in_vec.ready, s1_vld_reg)
    `ASSERT_IMPLIES(a_degenerate_identity, clk, rst_n,
        out_vld_reg && out_reg.degenerate, out_reg.m12 == 16'sd0 && out_reg.m21 == 16'sd0)

endmodule

`default_nettype wire

FILE: hdl/vara_div_stage.sv
// ---------------------------------------------------------------------------
// Division stage
// One restoring quotient bit for each of the six lanes, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module vara_div_stage
    import vara_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      vld_in,
    input  wire lane_vec_t lane_in,
    input  wire side_t     side_in,
    output logic           vld_out,
    output lane_vec_t      lane_out,
    output side_t          side_out
);

    logic      vld_reg;
    lane_vec_t lane_reg;
    lane_vec_t lane_next;
    side_t     side_reg;

    always_comb
    begin
        logic [64:0] sh;
        logic        ge;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            sh = {lane_in[l].rem, lane_in[l].lo[QBITS-1]};
            ge = (sh >= {1'b0, side_in.n});
            lane_next[l].rem = ge ? 64'(sh - {1'b0, side_in.n}) : sh[63:0];
            lane_next[l].lo  = {lane_in[l].lo[QBITS-2:0], 1'b0};
            lane_next[l].q   = {lane_in[l].q[QBITS-2:0], ge};
            lane_next[l].sat = lane_in[l].sat;
            lane_next[l].neg = lane_in[l].neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign lane_out = lane_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

FILE: verif/vector_align_rotation_matrix_test.sv
// ---------------------------------------------------------------------------
// Rotation matrix block test
// Drives vector pairs into the block, predicts each rotation matrix with an
// exact integer model, and compares every output transfer field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_align_rotation_matrix_test;
    import vara_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int IDLE_LIM  = 4000;
    localparam int N_RANDOM  = 680;

    logic clk;
    logic rst_n;

    vara_stream_if #(.T(vec_pair_t)) in_vec ();
    vara_stream_if #(.T(mat_t))      out_mat ();

    vector_align_rotation_matrix #(.FRAC_BITS(FB)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vec  (in_vec.sink),
        .out_mat (out_mat.source)
    );

    typedef struct {
        vec_pair_t pair;
        logic      has_gold;
        mat_t      gold;
    } stim_row_t;

    mat_t      pending_mats[$];
    stim_row_t stim_rows[$];
    int        error_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off_cycles;
    int        quiet_cycles;
    bit        sending_done;
    bit        hold_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic logic signed [15:0] sat16(input logic signed [127:0] x);
        if (x > 32767)
            return 16'sd32767;
        else if (x < -32768)
            return -16'sd32768;
        else
            return x[15:0];
    endfunction

    function automatic logic signed [15:0] round_entry(input logic signed [127:0] t);
        logic [127:0] m;
        m = (t < 0) ? -t : t;
        m = (m + (128'd1 << (FB - 1))) >> FB;
        if (m > 128'd65536)
            m = 128'd65536;
        return sat16((t < 0) ? -$signed(m) : $signed(m));
    endfunction

    function automatic mat_t rotation_of(input vec_pair_t p);
        logic signed [127:0] a[3], b[3], v[3], kk[3][3], k[3][3];
        logic signed [127:0] c, f, n, one2, t;
        logic [127:0]        q;
        logic signed [15:0]  e[3][3];
        mat_t                r;
        a[0] = 128'(p.from_x); a[1] = 128'(p.from_y); a[2] = 128'(p.from_z);
        b[0] = 128'(p.to_x);   b[1] = 128'(p.to_y);   b[2] = 128'(p.to_z);
        v[0] = a[1] * b[2] - a[2] * b[1];
        v[1] = a[2] * b[0] - a[0] * b[2];
        v[2] = a[0] * b[1] - a[1] * b[0];
        c = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        n = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        one2 = 128'sd1 << (2 * FB);
        if (n == 0)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    e[i][j] = (i == j) ? sat16(128'sd1 << FB) : 16'sd0;
        end
        else
        begin
            k[0][0] = 0;     k[0][1] = -v[2]; k[0][2] = v[1];
            k[1][0] = v[2];  k[1][1] = 0;     k[1][2] = -v[0];
            k[2][0] = -v[1]; k[2][1] = v[0];  k[2][2] = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    kk[i][j] = (i == j) ? -(n - v[i] * v[i]) : v[i] * v[j];
            f = one2 - c;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    q = ((kk[i][j] < 0 ? -kk[i][j] : kk[i][j]) * (f < 0 ? -f : f)) / n;
                    if (q > (128'd1 << 62))
                        q = 128'd1 << 62;
                    t = ((i == j) ? one2 : 128'sd0) + k[i][j];
                    t = ((kk[i][j] < 0) != (f < 0)) ? t - $signed(q) : t + $signed(q);
                    e[i][j] = round_entry(t);
                end
        end
        r.m11 = e[0][0]; r.m12 = e[0][1]; r.m13 = e[0][2];
        r.m21 = e[1][0]; r.m22 = e[1][1]; r.m23 = e[1][2];
        r.m31 = e[2][0]; r.m32 = e[2][1]; r.m33 = e[2][2];
        r.degenerate = (n == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic vec_pair_t make_pair(input int fx, fy, fz, tx, ty, tz);
        vec_pair_t p;
        p.from_x = 16'(fx); p.from_y = 16'(fy); p.from_z = 16'(fz);
        p.to_x = 16'(tx);   p.to_y = 16'(ty);   p.to_z = 16'(tz);
        return p;
    endfunction

    function automatic mat_t ident_mat();
        mat_t m;
        m = '0;
        m.m11 = 16'sd16384; m.m22 = 16'sd16384; m.m33 = 16'sd16384;
        m.degenerate = 1'b1;
        return m;
    endfunction

    task automatic add_row(input vec_pair_t p, input logic has_gold, input mat_t g);
        stim_row_t row;
        row.pair = p;
        row.has_gold = has_gold;
        row.gold = g;
        stim_rows.push_back(row);
    endtask

    function automatic logic signed [15:0] rand_comp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'($urandom);
        else if (sel == 1)
            return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
        else
            return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endfunction

    function automatic vec_pair_t rand_pair();
        vec_pair_t p;
        int        mode;
        p.from_x = rand_comp(); p.from_y = rand_comp(); p.from_z = rand_comp();
        p.to_x = rand_comp();   p.to_y = rand_comp();   p.to_z = rand_comp();
        mode = $urandom_range(0, 19);
        if (mode == 0)
        begin
            p.to_x = p.from_x; p.to_y = p.from_y; p.to_z = p.from_z;
        end
        else if (mode == 1)
        begin
            p.to_x = -p.from_x; p.to_y = -p.from_y; p.to_z = -p.from_z;
        end
        else if (mode == 2)
        begin
            p.from_x = 16'sd0; p.from_y = 16'sd0; p.from_z = 16'sd0;
        end
        return p;
    endfunction

    task automatic send_pair(input vec_pair_t p);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_vec.valid <= 1'b0;
            @(negedge clk);
        end
        in_vec.valid <= 1'b1;
        in_vec.data  <= p;
        @(posedge clk);
        while (!in_vec.ready)
            @(posedge clk);
        pending_mats.push_back(rotation_of(p));
        @(negedge clk);
    endtask

    initial
    begin
        mat_t id_mat;
        mat_t none_mat;
        id_mat = ident_mat();
        none_mat = '0;
        rst_n = 1'b0;
        in_vec.valid = 1'b0;
        in_vec.data = '0;
        send_idle_pct = 0;
        sending_done = 1'b0;

        add_row(make_pair(16384, 0, 0, 16384, 0, 0), 1'b1, id_mat);
        add_row(make_pair(16384, 0, 0, -16384, 0, 0), 1'b1, id_mat);
        add_row(make_pair(0, 0, 0, 0, 0, 0), 1'b1, id_mat);
        add_row(make_pair(-16384, -16384, -16384, -16384, -16384, -16384), 1'b1, id_mat);
        add_row(make_pair(-32768, 0, 0, 32767, 0, 0), 1'b1, id_mat);
        add_row(make_pair(16384, 0, 0, 0, 16384, 0), 1'b0, none_mat);
        add_row(make_pair(0, 16384, 0, 0, 0, 16384), 1'b0, none_mat);
        add_row(make_pair(0, 0, 16384, 16384, 0, 0), 1'b0, none_mat);
        add_row(make_pair(0, 16384, 0, 16384, 0, 0), 1'b0, none_mat);
        add_row(make_pair(16384, 0, 0, 0, 0, -16384), 1'b0, none_mat);
        add_row(make_pair(16384, 0, 0, 16383, 1, 0), 1'b0, none_mat);
        add_row(make_pair(16384, 0, 0, -16384, 1, 0), 1'b0, none_mat);
        add_row(make_pair(11585, 11585, 0, 0, 11585, 11585), 1'b0, none_mat);
        add_row(make_pair(9459, 9459, 9459, -9459, 9459, -9459), 1'b0, none_mat);
        add_row(make_pair(32767, -32768, 32767, -32768, 32767, -32768), 1'b0, none_mat);
        add_row(make_pair(-32768, -32768, -32768, 32767, -1, 0), 1'b0, none_mat);
        add_row(make_pair(1, 0, 0, 0, 1, 0), 1'b0, none_mat);
        add_row(make_pair(1, 0, 0, -32768, 1, 0), 1'b0, none_mat);
        add_row(make_pair(-1, -1, -1, 1, -1, 1), 1'b0, none_mat);
        add_row(make_pair(21845, -10922, 5461, -5461, 10922, -21845), 1'b0, none_mat);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_rows[r])
        begin
            send_pair(stim_rows[r].pair);
            if (stim_rows[r].has_gold)
                pending_mats[$] = stim_rows[r].gold;
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            send_idle_pct = (n < 230) ? 7 : (n < 460) ? 71 : 0;
            send_pair(rand_pair());
        end
        in_vec.valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial
    begin
        out_mat.ready = 1'b0;
        recv_idle_pct = 71;
        hold_off_cycles = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && send_idle_pct == 0 && recv_idle_pct == 0 && !sending_done)
            begin
                hold_done = 1'b1;
                hold_off_cycles = 150;
            end
            if (hold_off_cycles == 0 && $urandom_range(0, 999) == 0 && !sending_done)
                hold_off_cycles = 150;
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_mat.ready <= 1'b0;
            end
            else
                out_mat.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (send_idle_pct == 71)
                recv_idle_pct = 7;
            else if (send_idle_pct == 0 && recv_idle_pct == 7 && in_vec.valid)
                recv_idle_pct = 0;
        end
    end

    initial
    begin
        mat_t got;
        mat_t want;
        error_count = 0;
        quiet_cycles = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_vec.valid && in_vec.ready) || (out_mat.valid && out_mat.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (out_mat.valid && out_mat.ready)
            begin
                got = out_mat.data;
                if (pending_mats.size() == 0)
                begin
                    $display("unexpected result transfer at %0t", $time);
                    error_count++;
                end
                else
                begin
                    want = pending_mats.pop_front();
                    if (got.m11 != want.m11) report_mismatch("m11", got.m11, want.m11);
                    if (got.m12 != want.m12) report_mismatch("m12", got.m12, want.m12);
                    if (got.m13 != want.m13) report_mismatch("m13", got.m13, want.m13);
                    if (got.m21 != want.m21) report_mismatch("m21", got.m21, want.m21);
                    if (got.m22 != want.m22) report_mismatch("m22", got.m22, want.m22);
                    if (got.m23 != want.m23) report_mismatch("m23", got.m23, want.m23);
                    if (got.m31 != want.m31) report_mismatch("m31", got.m31, want.m31);
                    if (got.m32 != want.m32) report_mismatch("m32", got.m32, want.m32);
                    if (got.m33 != want.m33) report_mismatch("m33", got.m33, want.m33);
                    if (got.degenerate != want.degenerate)
                        report_mismatch("degenerate", got.degenerate, want.degenerate);
                end
            end
            if (quiet_cycles >= IDLE_LIM)
            begin
                $display("timeout at %0t", $time);
                $display("FAILED: results differ");
                $finish;
            end
            else if (sending_done && pending_mats.size() == 0)
            begin
                repeat (100) @(posedge clk);
                if (out_mat.valid)
                begin
                    $display("unexpected result transfer at %0t", $time);
                    error_count++;
                end
                if (error_count == 0)
                    $display("PASSED: all results match");
                else
                    $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

FILE: verif/vector_align_rotation_matrix_test_top_note.sv
// ---------------------------------------------------------------------------
// Test support
// No further units are needed; the testbench module stands on its own.
// ---------------------------------------------------------------------------

FILE: filelist.f
+incdir+hdl
hdl/vara_pkg.sv
hdl/vara_stream_if.sv
hdl/vara_div_stage.sv
hdl/vector_align_rotation_matrix.sv
verif/vector_align_rotation_matrix_test.sv
verif/vector_align_rotation_matrix_test_top_note.sv
